// ----- hdl/hsv_to_rgb_converter_defines.svh -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_defines
// Assertion macros used by the color converter RTL; compiled out when
// NO_ASSERTIONS is defined. The enclosing module provides clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define HSV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define HSV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HSV_ASSERT_IMP(lbl, ante, cons, msg)
`define HSV_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ----- hdl/hsv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Widths, constants and the sextant code of the hsv to rgb converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // field widths
  localparam int unsigned HUE_W  = 9;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned PROD_W = 2 * CH_W;   // v*s and 255*v - v*s
  localparam int unsigned K_W    = 6;          // k in 0..60
  localparam int unsigned HM_W   = 7;          // hue mod 120
  localparam int unsigned NUM_W  = 22;         // numerator over 15300

  // angles and scale
  localparam int unsigned DEG_SEXTANT = 60;
  localparam int unsigned DEG_THIRD   = 120;
  localparam int unsigned HUE_180     = 180;
  localparam int unsigned HUE_240     = 240;
  localparam int unsigned HUE_300     = 300;
  localparam int unsigned HUE_360     = 360;
  localparam int unsigned HUE_480     = 480;
  localparam int unsigned FULL_SCALE  = 255;
  localparam int unsigned DENOM       = FULL_SCALE * DEG_SEXTANT;

  // reciprocal division: q0 = (n * RECIP) >> SHIFT, low by at most one
  localparam int unsigned SHIFT_X = 24;
  localparam int unsigned RECIP_X = (1 << SHIFT_X) / DENOM;
  localparam int unsigned PX_W    = NUM_W + 11;
  localparam int unsigned SHIFT_M = 16;
  localparam int unsigned RECIP_M = (1 << SHIFT_M) / FULL_SCALE;
  localparam int unsigned PM_W    = PROD_W + 9;

  // sextant of the hue, names give the (r, g, b) roles
  typedef enum logic [2:0] {
    SEXT_CXZ = 3'd0,   // 0..59
    SEXT_XCZ = 3'd1,   // 60..119
    SEXT_ZCX = 3'd2,   // 120..179
    SEXT_ZXC = 3'd3,   // 180..239
    SEXT_XZC = 3'd4,   // 240..299
    SEXT_CZX = 3'd5    // 300 and above
  } sext_t;

endpackage

// ----- hdl/hsv_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Pipelined hsv to rgb color conversion with truncating fixed-point math.
// ----------------------------------------------------------------------------
// A color enters and its rgb passes through the stage registers: stage one
// forms v*s, hue mod 120 and the sextant, stage two the numerators, stage
// three the reciprocal multiplies, stage four the remainder correction and
// channel placement into the output register. One request per cycle is
// taken while the output is not stalled; out_stall holds only full stages,
// so bubbles are squeezed out and in_stall rises only when all four stages
// hold data. Hues of 360 and above land in the last sextant.
`include "hsv_to_rgb_converter_defines.svh"

module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [HUE_W-1:0] in_hue,
  input  logic [CH_W-1:0]  in_saturation,
  input  logic [CH_W-1:0]  in_brightness,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CH_W-1:0]  out_red,
  output logic [CH_W-1:0]  out_green,
  output logic [CH_W-1:0]  out_blue
);

  // stage enables, last stage first
  logic en1, en2, en3, en4;
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;

  assign en4 = !s4_vld_r || !out_stall;
  assign en3 = !s3_vld_r || en4;
  assign en2 = !s2_vld_r || en3;
  assign en1 = !s1_vld_r || en2;
  assign in_stall = !en1;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      if (en1) s1_vld_r <= in_valid;
      if (en2) s2_vld_r <= s1_vld_r;
      if (en3) s3_vld_r <= s2_vld_r;
      if (en4) s4_vld_r <= s3_vld_r;
    end
  end

  // stage 1: v*s, hue mod 120, k and sextant
  logic [PROD_W-1:0] s1_vs_r, s1_vs_nxt;
  logic [K_W-1:0]    s1_k_r, s1_k_nxt;
  sext_t             s1_sext_r, s1_sext_nxt;
  logic [CH_W-1:0]   s1_bri_r;
  logic [HM_W-1:0]   hue_mod;
  logic [HM_W-1:0]   hue_dist;

  always_comb begin
    s1_vs_nxt = PROD_W'(in_brightness) * PROD_W'(in_saturation);

    priority if (in_hue >= HUE_W'(HUE_480)) hue_mod = HM_W'(in_hue - HUE_W'(HUE_480));
    else if (in_hue >= HUE_W'(HUE_360))     hue_mod = HM_W'(in_hue - HUE_W'(HUE_360));
    else if (in_hue >= HUE_W'(HUE_240))     hue_mod = HM_W'(in_hue - HUE_W'(HUE_240));
    else if (in_hue >= HUE_W'(DEG_THIRD))   hue_mod = HM_W'(in_hue - HUE_W'(DEG_THIRD));
    else                                    hue_mod = HM_W'(in_hue);

    if (hue_mod >= HM_W'(DEG_SEXTANT)) begin
      hue_dist = hue_mod - HM_W'(DEG_SEXTANT);
    end else begin
      hue_dist = HM_W'(DEG_SEXTANT) - hue_mod;
    end
    s1_k_nxt = K_W'(HM_W'(DEG_SEXTANT) - hue_dist);

    priority if (in_hue < HUE_W'(DEG_SEXTANT)) s1_sext_nxt = SEXT_CXZ;
    else if (in_hue < HUE_W'(DEG_THIRD))       s1_sext_nxt = SEXT_XCZ;
    else if (in_hue < HUE_W'(HUE_180))         s1_sext_nxt = SEXT_ZCX;
    else if (in_hue < HUE_W'(HUE_240))         s1_sext_nxt = SEXT_ZXC;
    else if (in_hue < HUE_W'(HUE_300))         s1_sext_nxt = SEXT_XZC;
    else                                       s1_sext_nxt = SEXT_CZX;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_vs_r   <= s1_vs_nxt;
      s1_k_r    <= s1_k_nxt;
      s1_sext_r <= s1_sext_nxt;
      s1_bri_r  <= in_brightness;
    end
  end

  // stage 2: m numerator over 255 and x+m numerator over 15300
  logic [PROD_W-1:0] s2_base_r, s2_base_nxt;
  logic [NUM_W-1:0]  s2_num_r, s2_num_nxt;
  sext_t             s2_sext_r;
  logic [CH_W-1:0]   s2_bri_r;

  always_comb begin
    s2_base_nxt = PROD_W'({s1_bri_r, {CH_W{1'b0}}} - (PROD_W + 1)'(s1_bri_r)
                          - (PROD_W + 1)'(s1_vs_r));
    s2_num_nxt  = NUM_W'(s2_base_nxt) * NUM_W'(DEG_SEXTANT)
                + NUM_W'(s1_vs_r) * NUM_W'(s1_k_r);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_base_r <= s2_base_nxt;
      s2_num_r  <= s2_num_nxt;
      s2_sext_r <= s1_sext_r;
      s2_bri_r  <= s1_bri_r;
    end
  end

  // stage 3: reciprocal multiplies, estimates low by at most one
  logic [PX_W-1:0]   prod_x;
  logic [PM_W-1:0]   prod_m;
  logic [CH_W-1:0]   s3_q0x_r, s3_q0m_r;
  logic [PROD_W-1:0] s3_base_r;
  logic [NUM_W-1:0]  s3_num_r;
  sext_t             s3_sext_r;
  logic [CH_W-1:0]   s3_bri_r;

  assign prod_x = PX_W'(s2_num_r) * PX_W'(RECIP_X);
  assign prod_m = PM_W'(s2_base_r) * PM_W'(RECIP_M);

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_q0x_r  <= prod_x[SHIFT_X +: CH_W];
      s3_q0m_r  <= prod_m[SHIFT_M +: CH_W];
      s3_base_r <= s2_base_r;
      s3_num_r  <= s2_num_r;
      s3_sext_r <= s2_sext_r;
      s3_bri_r  <= s2_bri_r;
    end
  end

  // stage 4: remainder correction and channel placement
  logic [NUM_W-1:0]  rem_x;
  logic [PROD_W-1:0] rem_m;
  logic [CH_W-1:0]   ch_x, ch_m;
  logic [CH_W-1:0]   red_nxt, green_nxt, blue_nxt;
  logic [CH_W-1:0]   out_red_r, out_green_r, out_blue_r;

  always_comb begin
    rem_x = s3_num_r - NUM_W'(s3_q0x_r) * NUM_W'(DENOM);
    rem_m = s3_base_r - PROD_W'(s3_q0m_r) * PROD_W'(FULL_SCALE);
    ch_x  = s3_q0x_r + CH_W'(rem_x >= NUM_W'(DENOM));
    ch_m  = s3_q0m_r + CH_W'(rem_m >= PROD_W'(FULL_SCALE));

    unique case (s3_sext_r)
      SEXT_CXZ: begin red_nxt = s3_bri_r; green_nxt = ch_x;     blue_nxt = ch_m;     end
      SEXT_XCZ: begin red_nxt = ch_x;     green_nxt = s3_bri_r; blue_nxt = ch_m;     end
      SEXT_ZCX: begin red_nxt = ch_m;     green_nxt = s3_bri_r; blue_nxt = ch_x;     end
      SEXT_ZXC: begin red_nxt = ch_m;     green_nxt = ch_x;     blue_nxt = s3_bri_r; end
      SEXT_XZC: begin red_nxt = ch_x;     green_nxt = ch_m;     blue_nxt = s3_bri_r; end
      default:  begin red_nxt = s3_bri_r; green_nxt = ch_m;     blue_nxt = ch_x;     end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      out_red_r   <= red_nxt;
      out_green_r <= green_nxt;
      out_blue_r  <= blue_nxt;
    end
  end

  assign out_valid = s4_vld_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

  // reciprocal estimates are never off by more than one
  `HSV_ASSERT_IMP(a_rem_x_bound, s3_vld_r, rem_x < NUM_W'(2 * DENOM), "x quotient off by more than one")
  `HSV_ASSERT_IMP(a_rem_m_bound, s3_vld_r, rem_m < PROD_W'(2 * FULL_SCALE), "m quotient off by more than one")
  // input is held back only when every stage is full
  `HSV_ASSERT_IMP(a_stall_full, in_stall, s1_vld_r && s2_vld_r && s3_vld_r && s4_vld_r, "stall with a free stage")
  // a full stage behind a stalled output is kept
  `HSV_ASSERT_NXT(a_hold_s3, s3_vld_r && s4_vld_r && out_stall, s3_vld_r && $stable(s3_num_r), "stage three lost under stall")

endmodule

// ----- verif/rgb_color_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_color_checker
// Watches both channels of the hsv to rgb converter, predicts the rgb of
// every accepted request and compares each result against the oldest one.
// ----------------------------------------------------------------------------
module rgb_color_checker
  import hsv2rgb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [HUE_W-1:0] in_hue,
  input  logic [CH_W-1:0]  in_saturation,
  input  logic [CH_W-1:0]  in_brightness,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [CH_W-1:0]  out_red,
  input  logic [CH_W-1:0]  out_green,
  input  logic [CH_W-1:0]  out_blue,
  output int unsigned      n_errors,
  output int unsigned      n_waiting,
  output int unsigned      n_checked
);

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } color_t;

  // a predicted color together with the request it came from
  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  sat;
    logic [CH_W-1:0]  val;
    color_t           rgb;
  } pending_color_t;

  pending_color_t expected_colors[$];
  pending_color_t oldest;
  int unsigned    err_cnt;
  int unsigned    chk_cnt;

  // exact truncating conversion over the common denominator 255*60
  function automatic color_t convert_hsv(logic [HUE_W-1:0] hue, logic [CH_W-1:0] sat,
                                         logic [CH_W-1:0] val);
    int unsigned     h;
    int unsigned     v;
    int unsigned     vs;
    int unsigned     hm;
    int unsigned     k;
    int unsigned     m_num;
    int unsigned     x_num;
    logic [CH_W-1:0] c_ch;
    logic [CH_W-1:0] x_ch;
    logic [CH_W-1:0] m_ch;
    sext_t           sext;
    color_t          rgb;
    h     = 32'(hue);
    v     = 32'(val);
    vs    = v * 32'(sat);
    hm    = h % DEG_THIRD;
    k     = (hm >= DEG_SEXTANT) ? (DEG_THIRD - hm) : hm;
    m_num = DEG_SEXTANT * (FULL_SCALE * v - vs);
    x_num = m_num + vs * k;
    c_ch  = val;
    m_ch  = CH_W'(m_num / DENOM);
    x_ch  = CH_W'(x_num / DENOM);
    // sextant picks the channel roles, out-of-range hues fall in the last one
    if (h < DEG_SEXTANT) sext = SEXT_CXZ;
    else if (h < DEG_THIRD) sext = SEXT_XCZ;
    else if (h < HUE_180) sext = SEXT_ZCX;
    else if (h < HUE_240) sext = SEXT_ZXC;
    else if (h < HUE_300) sext = SEXT_XZC;
    else sext = SEXT_CZX;
    case (sext)
      SEXT_CXZ: rgb = '{red: c_ch, green: x_ch, blue: m_ch};
      SEXT_XCZ: rgb = '{red: x_ch, green: c_ch, blue: m_ch};
      SEXT_ZCX: rgb = '{red: m_ch, green: c_ch, blue: x_ch};
      SEXT_ZXC: rgb = '{red: m_ch, green: x_ch, blue: c_ch};
      SEXT_XZC: rgb = '{red: x_ch, green: m_ch, blue: c_ch};
      default:  rgb = '{red: c_ch, green: m_ch, blue: x_ch};
    endcase
    return rgb;
  endfunction

  // compare results first, then queue the new request of the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_colors.size() == 0) begin
          $error("result r=%0d g=%0d b=%0d with no request pending",
                 out_red, out_green, out_blue);
          err_cnt++;
        end else begin
          oldest = expected_colors.pop_front();
          chk_cnt++;
          if (out_red !== oldest.rgb.red) begin
            $error("red: expected %0d, got %0d (hue %0d sat %0d val %0d)",
                   oldest.rgb.red, out_red, oldest.hue, oldest.sat, oldest.val);
            err_cnt++;
          end
          if (out_green !== oldest.rgb.green) begin
            $error("green: expected %0d, got %0d (hue %0d sat %0d val %0d)",
                   oldest.rgb.green, out_green, oldest.hue, oldest.sat, oldest.val);
            err_cnt++;
          end
          if (out_blue !== oldest.rgb.blue) begin
            $error("blue: expected %0d, got %0d (hue %0d sat %0d val %0d)",
                   oldest.rgb.blue, out_blue, oldest.hue, oldest.sat, oldest.val);
            err_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_colors.push_back('{hue: in_hue, sat: in_saturation, val: in_brightness,
                                    rgb: convert_hsv(in_hue, in_saturation, in_brightness)});
      end
      n_errors  <= err_cnt;
      n_checked <= chk_cnt;
      n_waiting <= expected_colors.size();
    end
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench top of the hsv to rgb converter: drives directed corner colors
// and random colors with random gaps and output stalls, including one long
// output hold-off, and reports the verdict from the color checker.
// ----------------------------------------------------------------------------
module tb;
  import hsv2rgb_pkg::*;

  localparam int unsigned RANDOM_COLORS = 1150;
  localparam int unsigned IDLE_LIMIT    = 3000;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned HOLD_AFTER    = 400;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [HUE_W-1:0] in_hue;
  logic [CH_W-1:0]  in_saturation;
  logic [CH_W-1:0]  in_brightness;
  logic             out_valid;
  logic             out_stall;
  logic [CH_W-1:0]  out_red;
  logic [CH_W-1:0]  out_green;
  logic [CH_W-1:0]  out_blue;

  int unsigned n_errors;
  int unsigned n_waiting;
  int unsigned n_checked;
  int unsigned colors_sent;
  int unsigned idle_cycles;
  bit          tx_quiet;
  bit          held_off;

  hsv_to_rgb_converter dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  rgb_color_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .n_errors      (n_errors),
    .n_waiting     (n_waiting),
    .n_checked     (n_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // offer one request and hold it until taken, then maybe idle a while
  task automatic send_color(logic [HUE_W-1:0] hue, logic [CH_W-1:0] sat,
                            logic [CH_W-1:0] val);
    int unsigned r;
    int unsigned gap;
    in_hue        <= hue;
    in_saturation <= sat;
    in_brightness <= val;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    colors_sent++;
    r = $urandom_range(0, 99);
    if (tx_quiet || r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // mostly in-range hues, some sextant edges and some past 359
  function automatic logic [HUE_W-1:0] pick_hue();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return HUE_W'($urandom_range(HUE_360, (1 << HUE_W) - 1));
    if (r == 1) return HUE_W'(DEG_SEXTANT * $urandom_range(0, 5) +
                              ($urandom_range(0, 1) ? 0 : DEG_SEXTANT - 1));
    return HUE_W'($urandom_range(0, HUE_360 - 1));
  endfunction

  function automatic logic [CH_W-1:0] pick_fraction();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return CH_W'(FULL_SCALE);
    return CH_W'($urandom_range(0, FULL_SCALE));
  endfunction

  // request side
  initial begin : stimulus
    static logic [HUE_W-1:0] dir_hue [22] = '{0, 0, 59, 60, 119, 120, 179, 180, 239, 240,
                                              299, 300, 359, 360, 419, 480, 511, 30, 90,
                                              150, 210, 270};
    static logic [CH_W-1:0]  dir_sat [22] = '{0, 255, 255, 255, 255, 255, 255, 255, 255,
                                              255, 255, 255, 255, 255, 170, 255, 255, 0,
                                              255, 1, 128, 254};
    static logic [CH_W-1:0]  dir_val [22] = '{0, 255, 255, 255, 255, 255, 255, 255, 255,
                                              255, 255, 255, 255, 255, 85, 128, 255, 255,
                                              0, 1, 200, 253};
    colors_sent = 0;
    tx_quiet    = 1'b0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_hue        <= '0;
    in_saturation <= '0;
    in_brightness <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner colors: black, white, sextant edges, out-of-range hues
    for (int i = 0; i < 22; i++) send_color(dir_hue[i], dir_sat[i], dir_val[i]);

    // random colors, with stretches of back-to-back requests
    for (int i = 0; i < RANDOM_COLORS; i++) begin
      if (i % 128 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
      send_color(pick_hue(), pick_fraction(), pick_fraction());
    end
    in_valid <= 1'b0;

    // drain, then wait for anything stray
    @(posedge clk);
    while (n_waiting != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("summary: %0d colors sent (corners, all sextants, hues up to 511)", colors_sent);
    $display("summary: %0d results checked, random gaps, stalls and one long hold-off",
             n_checked);
    if (n_errors == 0 && n_waiting == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // result side: random stalls, quiet stretches and one long hold-off
  initial begin : receiver
    int unsigned stall_left;
    int unsigned cycle_cnt;
    int unsigned r;
    bit          rx_quiet;
    stall_left = 0;
    cycle_cnt  = 0;
    rx_quiet   = 1'b0;
    held_off   = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt % 256 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      if (!held_off && colors_sent >= HOLD_AFTER) begin
        // fill the pipe while the sender keeps offering
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (rx_quiet || r < 70) begin
          out_stall <= 1'b0;
        end else begin
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
          out_stall <= 1'b1;
        end
      end
    end
  end

  // watchdog on cycles where neither channel moves
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
          $display("tb: done, errors");
          $finish;
        end
      end
    end
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/hsv2rgb_pkg.sv
hdl/hsv_to_rgb_converter.sv
verif/rgb_color_checker.sv
verif/tb.sv
